// ----- hw/rtl/arpc_pkg.sv -----
// ----------------------------------------------------------------------------
// arpc_pkg: shared types and constants of the ARP cache
// Entry status and action codes, register indexes, beat payloads and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned Entries    = 16;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned CntW       = 5;   // holds 0..MaxResults

  localparam logic [15:0] OpRequest = 16'd1;
  localparam logic [15:0] OpReply   = 16'd2;

  localparam logic [47:0] MacBroadcast = 48'hFFFF_FFFF_FFFF;

  localparam logic [7:0] EntryTimeoutRst   = 8'd5;
  localparam logic [7:0] PendingTimeoutRst = 8'd3;
  localparam logic [7:0] MaxRetriesRst     = 8'd3;

  typedef enum logic [1:0] {
    CfgEntryTimeout   = 2'd0,
    CfgPendingTimeout = 2'd1,
    CfgMaxRetries     = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StFree      = 2'd0,
    StOk        = 2'd1,
    StResolving = 2'd2
  } ent_st_e;

  typedef enum logic [2:0] {
    ActReply     = 3'd0,
    ActUnicast   = 3'd1,
    ActBroadcast = 3'd2,
    ActFreed     = 3'd3,
    ActFull      = 3'd4
  } act_e;

  typedef enum logic [1:0] {
    EmitTick  = 2'd0,
    EmitFull  = 2'd1,
    EmitReply = 2'd2
  } emit_sel_e;

  typedef enum logic [2:0] {
    CtlIdle  = 3'd0,
    CtlWalk  = 3'd1,
    CtlFull  = 3'd2,
    CtlReply = 3'd3,
    CtlFlush = 3'd4
  } ctl_state_e;

  typedef struct packed {
    logic        mode;
    logic [15:0] opcode;
    logic [31:0] src_ip;
    logic [47:0] src_mac;
  } in_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] target_ip;
    logic [47:0] target_mac;
    logic [3:0]  slot;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
    logic [7:0]  cnt;
    logic [7:0]  ret;
  } ent_t;

  typedef struct packed {
    logic      load;
    logic      step;
    logic      commit;
    logic      emit;
    emit_sel_e emit_sel;
    logic      flush;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_walk;
    logic tick_mode;
    logic op_req;
    logic last_entry;
    logic found;
    logic tick_emit;
    logic emit_ok;
    logic walk_stall;
    logic hold_v;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- hw/rtl/arpc_ctrl.sv -----
// ----------------------------------------------------------------------------
// arpc_ctrl: sequencing controller of the ARP cache
// Accepts an item, walks the table, issues the packet results and flushes
// the last held result with its last flag.
// ----------------------------------------------------------------------------
module arpc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  arpc_pkg::dp_sts_t sts_i,
  output arpc_pkg::ctl_cmd_t cmd_o
);

  arpc_pkg::ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= arpc_pkg::CtlIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      arpc_pkg::CtlIdle: begin
        if (in_valid_i && sts_i.in_walk) begin
          state_d = arpc_pkg::CtlWalk;
        end
      end
      arpc_pkg::CtlWalk: begin
        if (!sts_i.walk_stall && sts_i.last_entry) begin
          if (sts_i.tick_mode) begin
            state_d = arpc_pkg::CtlFlush;
          end else if (!sts_i.found) begin
            state_d = arpc_pkg::CtlFull;
          end else if (sts_i.op_req) begin
            state_d = arpc_pkg::CtlReply;
          end else begin
            state_d = arpc_pkg::CtlFlush;
          end
        end
      end
      arpc_pkg::CtlFull: begin
        if (sts_i.emit_ok) begin
          state_d = sts_i.op_req ? arpc_pkg::CtlReply : arpc_pkg::CtlFlush;
        end
      end
      arpc_pkg::CtlReply: begin
        if (sts_i.emit_ok) begin
          state_d = arpc_pkg::CtlFlush;
        end
      end
      arpc_pkg::CtlFlush: begin
        if (!sts_i.hold_v || sts_i.out_free) begin
          state_d = arpc_pkg::CtlIdle;
        end
      end
      default: begin
        state_d = arpc_pkg::CtlIdle;
      end
    endcase
  end

  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    cmd_o.emit_sel = arpc_pkg::EmitTick;
    case (state_q)
      arpc_pkg::CtlIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      arpc_pkg::CtlWalk: begin
        cmd_o.step   = !sts_i.walk_stall;
        cmd_o.emit   = !sts_i.walk_stall && sts_i.tick_mode && sts_i.tick_emit;
        // The new entry is written on the final lookup cycle.
        cmd_o.commit = !sts_i.walk_stall && sts_i.last_entry && !sts_i.tick_mode &&
                       sts_i.found;
      end
      arpc_pkg::CtlFull: begin
        cmd_o.emit     = sts_i.emit_ok;
        cmd_o.emit_sel = arpc_pkg::EmitFull;
      end
      arpc_pkg::CtlReply: begin
        cmd_o.emit     = sts_i.emit_ok;
        cmd_o.emit_sel = arpc_pkg::EmitReply;
      end
      arpc_pkg::CtlFlush: begin
        cmd_o.flush = sts_i.hold_v && sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/arpc_dpath.sv -----
// ----------------------------------------------------------------------------
// arpc_dpath: table, aging logic and result registers of the ARP cache
// Holds the entry memory and status flops, evaluates one entry per step and
// passes results through a hold register into the output register.
// ----------------------------------------------------------------------------
module arpc_dpath #(
  parameter int unsigned ENTRIES = arpc_pkg::Entries
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  arpc_pkg::in_t      in_data_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  input  arpc_pkg::ctl_cmd_t cmd_i,
  output arpc_pkg::dp_sts_t  sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output arpc_pkg::out_t     out_data_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);

  // Configuration registers.
  logic [7:0] entry_to_q, pend_to_q, max_ret_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_to_q <= arpc_pkg::EntryTimeoutRst;
      pend_to_q  <= arpc_pkg::PendingTimeoutRst;
      max_ret_q  <= arpc_pkg::MaxRetriesRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        arpc_pkg::CfgEntryTimeout:   entry_to_q <= cfg_data_i;
        arpc_pkg::CfgPendingTimeout: pend_to_q  <= cfg_data_i;
        arpc_pkg::CfgMaxRetries:     max_ret_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Item register.
  arpc_pkg::in_t in_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_data_i;
    end
  end

  logic tick_mode, op_req;
  assign tick_mode = in_q.mode;
  assign op_req    = (in_q.opcode == arpc_pkg::OpRequest);

  // Walk index.
  logic [IW-1:0] idx_q, idx_d, rd_addr;
  logic          last_entry;

  assign last_entry = (idx_q == LastIdx);

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.load) begin
      idx_d = '0;
    end else if (cmd_i.step) begin
      idx_d = last_entry ? '0 : idx_q + 1'b1;
    end
  end

  // The read address runs one entry ahead so that the registered read data
  // belongs to idx_q in the following cycle.
  assign rd_addr = idx_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // Entry memory and status flops.
  arpc_pkg::ent_t   mem [ENTRIES];
  arpc_pkg::ent_t   rdata_q;
  arpc_pkg::ent_st_e st_q [ENTRIES];

  logic              mem_we;
  logic [IW-1:0]     wr_addr;
  arpc_pkg::ent_t    wr_ent, tick_ent;
  arpc_pkg::ent_st_e wr_st, tick_st, cur_st;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_ent;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        st_q[i] <= arpc_pkg::StFree;
      end
    end else if (mem_we) begin
      st_q[wr_addr] <= wr_st;
    end
  end

  assign cur_st = st_q[idx_q];

  // Aging of one entry on a tick.
  logic [7:0]           cnt_dec, ret_dec;
  logic                 tick_emit;
  arpc_pkg::act_e       tick_act;
  logic [47:0]          tick_mac;

  assign cnt_dec = rdata_q.cnt - 8'd1;
  assign ret_dec = rdata_q.ret - 8'd1;

  always_comb begin
    tick_ent  = rdata_q;
    tick_st   = cur_st;
    tick_emit = 1'b0;
    tick_act  = arpc_pkg::ActUnicast;
    tick_mac  = rdata_q.mac;
    case (cur_st)
      arpc_pkg::StOk: begin
        tick_ent.cnt = cnt_dec;
        if (cnt_dec == 8'd0) begin
          tick_emit    = 1'b1;
          tick_st      = arpc_pkg::StResolving;
          tick_ent.cnt = pend_to_q;
        end
      end
      arpc_pkg::StResolving: begin
        tick_ent.cnt = cnt_dec;
        if (cnt_dec == 8'd0) begin
          tick_ent.ret = ret_dec;
          tick_emit    = 1'b1;
          if (ret_dec == 8'd0) begin
            tick_st  = arpc_pkg::StFree;
            tick_act = arpc_pkg::ActFreed;
          end else begin
            tick_act     = arpc_pkg::ActBroadcast;
            tick_mac     = arpc_pkg::MacBroadcast;
            tick_ent.cnt = pend_to_q;
          end
        end
      end
      default: begin
        tick_emit = 1'b0;
      end
    endcase
  end

  // Lookup: first matching entry and first free slot.
  logic          hit_v_q, hit_v_d, free_v_q, free_v_d;
  logic [IW-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d, tgt_idx;
  logic          is_match, is_free, found;

  assign is_match = (cur_st == arpc_pkg::StOk || cur_st == arpc_pkg::StResolving) &&
                    (rdata_q.ip == in_q.src_ip);
  assign is_free  = (cur_st == arpc_pkg::StFree);

  always_comb begin
    hit_v_d    = hit_v_q;
    hit_idx_d  = hit_idx_q;
    free_v_d   = free_v_q;
    free_idx_d = free_idx_q;
    if (cmd_i.load) begin
      hit_v_d  = 1'b0;
      free_v_d = 1'b0;
    end else if (cmd_i.step && !tick_mode) begin
      if (is_match) begin
        if (!hit_v_q) begin
          hit_v_d   = 1'b1;
          hit_idx_d = idx_q;
        end
      end else if (is_free && !free_v_q) begin
        free_v_d   = 1'b1;
        free_idx_d = idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_v_q  <= 1'b0;
      free_v_q <= 1'b0;
    end else begin
      hit_v_q  <= hit_v_d;
      free_v_q <= free_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
  end

  assign found   = hit_v_d || free_v_d;
  assign tgt_idx = hit_v_d ? hit_idx_d : free_idx_d;

  // Single write port: aging write-back or the packet refresh.
  always_comb begin
    mem_we  = 1'b0;
    wr_addr = idx_q;
    wr_ent  = tick_ent;
    wr_st   = tick_st;
    if (cmd_i.commit) begin
      mem_we  = 1'b1;
      wr_addr = tgt_idx;
      wr_ent  = '{ip: in_q.src_ip, mac: in_q.src_mac, cnt: entry_to_q,
                  ret: max_ret_q};
      wr_st   = arpc_pkg::StOk;
    end else if (cmd_i.step && tick_mode) begin
      mem_we = 1'b1;
    end
  end

  // Result path: a held result goes out only once the next one (or the end
  // of the item) shows whether it is the last.
  arpc_pkg::out_t       new_res, hold_q, out_q, move_res;
  logic                 hold_v_q, out_v_q, out_v_d;
  logic [arpc_pkg::CntW-1:0] res_cnt_q;
  logic                 cap, keep, move, out_free, emit_ok;

  always_comb begin
    new_res.last = 1'b0;
    case (cmd_i.emit_sel)
      arpc_pkg::EmitTick: begin
        new_res.action     = tick_act;
        new_res.target_ip  = rdata_q.ip;
        new_res.target_mac = tick_mac;
        new_res.slot       = 4'(idx_q);
      end
      arpc_pkg::EmitFull: begin
        new_res.action     = arpc_pkg::ActFull;
        new_res.target_ip  = in_q.src_ip;
        new_res.target_mac = in_q.src_mac;
        new_res.slot       = 4'd0;
      end
      default: begin
        new_res.action     = arpc_pkg::ActReply;
        new_res.target_ip  = in_q.src_ip;
        new_res.target_mac = in_q.src_mac;
        new_res.slot       = found ? 4'(tgt_idx) : 4'd0;
      end
    endcase
  end

  assign cap      = (res_cnt_q == arpc_pkg::CntW'(arpc_pkg::MaxResults));
  assign out_free = !out_v_q || out_ready_i;
  assign emit_ok  = cap || !hold_v_q || out_free;
  assign keep     = cmd_i.emit && !cap;
  assign move     = (keep && hold_v_q) || cmd_i.flush;

  always_comb begin
    out_v_d = out_v_q && !out_ready_i;
    if (move) begin
      out_v_d = 1'b1;
    end
  end

  always_comb begin
    move_res      = hold_q;
    move_res.last = cmd_i.flush;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      res_cnt_q <= '0;
    end else begin
      out_v_q <= out_v_d;
      if (cmd_i.load) begin
        res_cnt_q <= '0;
      end else if (keep) begin
        res_cnt_q <= res_cnt_q + 1'b1;
      end
      if (keep) begin
        hold_v_q <= 1'b1;
      end else if (cmd_i.flush) begin
        hold_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (keep) begin
      hold_q <= new_res;
    end
    if (move) begin
      out_q <= move_res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  assign sts_o.in_walk    = in_data_i.mode || (in_data_i.opcode == arpc_pkg::OpRequest) ||
                            (in_data_i.opcode == arpc_pkg::OpReply);
  assign sts_o.tick_mode  = tick_mode;
  assign sts_o.op_req     = op_req;
  assign sts_o.last_entry = last_entry;
  assign sts_o.found      = found;
  assign sts_o.tick_emit  = tick_emit;
  assign sts_o.emit_ok    = emit_ok;
  assign sts_o.walk_stall = tick_mode && tick_emit && !emit_ok;
  assign sts_o.hold_v     = hold_v_q;
  assign sts_o.out_free   = out_free;

endmodule

// ----- hw/rtl/arp_cache_aging_retry.sv -----
// ----------------------------------------------------------------------------
// arp_cache_aging_retry: ARP cache with per-entry aging and retry
// Top level joining the sequencing controller and the table datapath.
// ----------------------------------------------------------------------------
// An item is accepted in the idle state, then walks the table one entry per
// step (ENTRIES, 16 by default) over the entry memory with its single write
// port, stalling when a tick result has no room; a packet then issues its
// table-full and send-reply results and the final result is released. A
// packet with an opcode other than request or reply is accepted without a
// walk. Results of one item leave in slot order, the last one flagged; at
// most 16 results are delivered per item. Configuration writes take effect
// at once and belong between items.
module arp_cache_aging_retry #(
  parameter int unsigned ENTRIES = arpc_pkg::Entries
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  arpc_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output arpc_pkg::out_t out_data_o,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [7:0]     cfg_data_i
);

  arpc_pkg::ctl_cmd_t cmd;
  arpc_pkg::dp_sts_t  sts;

  arpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  arpc_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // No result of the previous item may still be held when a new one enters.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_ready_o |-> !sts.hold_v)
    else $error("held result left over at item accept");

  // The walk never advances past an entry whose result has no room.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cmd.step && sts.walk_stall))
    else $error("walk advanced while stalled");

  // The final result is only released into a free output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.flush |-> sts.out_free)
    else $error("flush into a busy output register");

  // An entry is only written back by a packet when a slot was found.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd.commit |-> sts.found)
    else $error("refresh without a target slot");

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking testbench of the ARP cache with aging and retry
// A short directed table walks the table-full, reply, ignored-opcode and
// mass-expiry cases. Random phases with several timer settings and idling
// patterns follow, each beat checked against an in-bench model of the table.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    arpc_pkg::in_t  item;
    logic           typed;
    logic [1:0]     n_res;
    arpc_pkg::out_t r0;
    arpc_pkg::out_t r1;
  } dir_row_t;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_ready_o;
  arpc_pkg::in_t  in_data_i = '0;
  logic           out_valid_o;
  logic           out_ready_i = 1'b0;
  arpc_pkg::out_t out_data_o;
  logic           cfg_we_i = 1'b0;
  logic [1:0]     cfg_idx_i = '0;
  logic [7:0]     cfg_data_i = '0;

  // Model of the cache table and its timer registers.
  arpc_pkg::ent_st_e tbl_status[arpc_pkg::Entries];
  logic [31:0]       tbl_ip[arpc_pkg::Entries];
  logic [47:0]       tbl_mac[arpc_pkg::Entries];
  logic [7:0]        tbl_cnt[arpc_pkg::Entries];
  logic [7:0]        tbl_retry[arpc_pkg::Entries];
  logic [7:0]        entry_to, pending_to, retry_budget;

  arpc_pkg::out_t step_q[$];
  arpc_pkg::out_t pending_actions[$];
  dir_row_t       directed_rows[$];
  logic [31:0]    ip_pool[24];
  int unsigned    idle_pct = 0;
  int unsigned    stall_pct = 0;
  int unsigned    error_count = 0;

  arp_cache_aging_retry DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  initial begin
    #10_000_000;
    $display("[arp_cache_aging_retry] ERROR");
    $finish;
  end

  function automatic void flag_error(string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void add_result(arpc_pkg::act_e a, logic [31:0] ip, logic [47:0] mac,
                                     int slot);
    arpc_pkg::out_t r;
    if (step_q.size() >= arpc_pkg::MaxResults) return;
    r.action     = a;
    r.target_ip  = ip;
    r.target_mac = mac;
    r.slot       = 4'(slot);
    r.last       = 1'b0;
    step_q = {step_q, r};
  endfunction

  // Computes the actions one input item causes and updates the table.
  function automatic void arp_table_step(arpc_pkg::in_t d);
    int hit, free_slot;
    hit = -1;
    free_slot = -1;
    step_q.delete();
    if (d.mode) begin
      for (int i = 0; i < arpc_pkg::Entries; i++) begin
        if (tbl_status[i] == arpc_pkg::StOk) begin
          tbl_cnt[i] = tbl_cnt[i] - 8'd1;
          if (tbl_cnt[i] == 8'd0) begin
            add_result(arpc_pkg::ActUnicast, tbl_ip[i], tbl_mac[i], i);
            tbl_status[i] = arpc_pkg::StResolving;
            tbl_cnt[i] = pending_to;
          end
        end else if (tbl_status[i] == arpc_pkg::StResolving) begin
          tbl_cnt[i] = tbl_cnt[i] - 8'd1;
          if (tbl_cnt[i] == 8'd0) begin
            tbl_retry[i] = tbl_retry[i] - 8'd1;
            if (tbl_retry[i] == 8'd0) begin
              tbl_status[i] = arpc_pkg::StFree;
              add_result(arpc_pkg::ActFreed, tbl_ip[i], tbl_mac[i], i);
            end else begin
              add_result(arpc_pkg::ActBroadcast, tbl_ip[i], arpc_pkg::MacBroadcast, i);
              tbl_cnt[i] = pending_to;
            end
          end
        end
      end
    end else if (d.opcode == arpc_pkg::OpRequest || d.opcode == arpc_pkg::OpReply) begin
      for (int i = 0; i < arpc_pkg::Entries; i++) begin
        if ((tbl_status[i] == arpc_pkg::StOk || tbl_status[i] == arpc_pkg::StResolving) &&
            tbl_ip[i] == d.src_ip) begin
          if (hit < 0) hit = i;
        end else if (tbl_status[i] == arpc_pkg::StFree && free_slot < 0) begin
          free_slot = i;
        end
      end
      if (hit < 0 && free_slot >= 0) begin
        hit = free_slot;
        tbl_ip[hit] = d.src_ip;
      end
      if (hit >= 0) begin
        tbl_mac[hit]    = d.src_mac;
        tbl_status[hit] = arpc_pkg::StOk;
        tbl_cnt[hit]    = entry_to;
        tbl_retry[hit]  = retry_budget;
      end else begin
        add_result(arpc_pkg::ActFull, d.src_ip, d.src_mac, 0);
      end
      if (d.opcode == arpc_pkg::OpRequest)
        add_result(arpc_pkg::ActReply, d.src_ip, d.src_mac, hit >= 0 ? hit : 0);
    end
    if (step_q.size() != 0) step_q[$].last = 1'b1;
  endfunction

  function automatic arpc_pkg::in_t pkt(logic [15:0] op, logic [31:0] ip, logic [47:0] mac);
    arpc_pkg::in_t d;
    d.mode    = 1'b0;
    d.opcode  = op;
    d.src_ip  = ip;
    d.src_mac = mac;
    return d;
  endfunction

  function automatic arpc_pkg::in_t tick_item(logic [15:0] op);
    arpc_pkg::in_t d;
    d = pkt(op, $urandom, {16'($urandom), 32'($urandom)});
    d.mode = 1'b1;
    return d;
  endfunction

  function automatic arpc_pkg::out_t res(arpc_pkg::act_e a, logic [31:0] ip, logic [47:0] mac,
                                         logic [3:0] slot, logic last);
    arpc_pkg::out_t r;
    r.action     = a;
    r.target_ip  = ip;
    r.target_mac = mac;
    r.slot       = slot;
    r.last       = last;
    return r;
  endfunction

  function automatic void add_row(arpc_pkg::in_t d, logic typed, logic [1:0] n,
                                  arpc_pkg::out_t r0, arpc_pkg::out_t r1);
    dir_row_t row;
    row.item  = d;
    row.typed = typed;
    row.n_res = n;
    row.r0    = r0;
    row.r1    = r1;
    directed_rows = {directed_rows, row};
  endfunction

  function automatic arpc_pkg::in_t rand_item();
    int unsigned pick;
    arpc_pkg::in_t d;
    pick = $urandom_range(99);
    if (pick < 30) begin
      d = tick_item(16'($urandom));
    end else if (pick < 90) begin
      d = pkt($urandom_range(1) ? arpc_pkg::OpRequest : arpc_pkg::OpReply,
              ip_pool[$urandom_range(23)], {16'($urandom), 32'($urandom)});
    end else begin
      d = pkt(16'($urandom), $urandom_range(1) ? ip_pool[$urandom_range(23)] : $urandom,
              {16'($urandom), 32'($urandom)});
    end
    return d;
  endfunction

  task automatic write_cfg(arpc_pkg::cfg_idx_e idx, logic [7:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    case (idx)
      arpc_pkg::CfgEntryTimeout:   entry_to = v;
      arpc_pkg::CfgPendingTimeout: pending_to = v;
      arpc_pkg::CfgMaxRetries:     retry_budget = v;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [7:0] et, logic [7:0] pt, logic [7:0] mr);
    write_cfg(arpc_pkg::CfgEntryTimeout, et);
    write_cfg(arpc_pkg::CfgPendingTimeout, pt);
    write_cfg(arpc_pkg::CfgMaxRetries, mr);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Lets all outstanding beats drain, then idles with no item offered.
  task automatic drain_and_settle();
    in_valid_i <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
  endtask

  task automatic send_item(arpc_pkg::in_t d, logic keep);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    in_data_i  <= d;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    arp_table_step(d);
    if (keep) pending_actions = {pending_actions, step_q};
  endtask

  task automatic run_phase(logic [7:0] et, logic [7:0] pt, logic [7:0] mr,
                           int unsigned idle, int unsigned stall, int unsigned items);
    int unsigned counted;
    arpc_pkg::in_t d;
    counted = 0;
    drain_and_settle();
    set_config(et, pt, mr);
    idle_pct  = idle;
    stall_pct = stall;
    while (counted < items) begin
      d = rand_item();
      send_item(d, 1'b1);
      // Ignored opcodes do not count toward the phase length.
      if (d.mode || d.opcode == arpc_pkg::OpRequest || d.opcode == arpc_pkg::OpReply)
        counted++;
    end
  endtask

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk_i) begin : result_check
    arpc_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_actions.size() == 0) begin
        flag_error($sformatf("unexpected beat action %0d ip 0x%0h mac 0x%0h slot %0d last %0d",
                             out_data_o.action, out_data_o.target_ip, out_data_o.target_mac,
                             out_data_o.slot, out_data_o.last));
      end else begin
        want = pending_actions.pop_front();
        if (want.action !== out_data_o.action)
          flag_error($sformatf("action: expected %0d, got %0d", want.action, out_data_o.action));
        if (want.target_ip !== out_data_o.target_ip)
          flag_error($sformatf("target_ip: expected 0x%0h, got 0x%0h",
                               want.target_ip, out_data_o.target_ip));
        if (want.target_mac !== out_data_o.target_mac)
          flag_error($sformatf("target_mac: expected 0x%0h, got 0x%0h",
                               want.target_mac, out_data_o.target_mac));
        if (want.slot !== out_data_o.slot)
          flag_error($sformatf("slot: expected %0d, got %0d", want.slot, out_data_o.slot));
        if (want.last !== out_data_o.last)
          flag_error($sformatf("last: expected %0d, got %0d", want.last, out_data_o.last));
      end
    end
  end

  initial begin
    int unsigned waited;
    arpc_pkg::out_t none;
    none = '0;
    foreach (tbl_status[i]) tbl_status[i] = arpc_pkg::StFree;
    entry_to     = arpc_pkg::EntryTimeoutRst;
    pending_to   = arpc_pkg::PendingTimeoutRst;
    retry_budget = arpc_pkg::MaxRetriesRst;
    foreach (ip_pool[i]) ip_pool[i] = $urandom;

    // Empty table: a tick and ignored opcodes cause nothing, then packets fill the table.
    add_row(tick_item(16'($urandom)), 1'b1, 2'd0, none, none);
    add_row(pkt(16'h0000, $urandom, 48'h0), 1'b1, 2'd0, none, none);
    add_row(pkt(16'hFFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF), 1'b1, 2'd0, none, none);
    add_row(pkt(arpc_pkg::OpRequest, 32'h0, 48'h0), 1'b1, 2'd1,
            res(arpc_pkg::ActReply, 32'h0, 48'h0, 4'd0, 1'b1), none);
    add_row(pkt(arpc_pkg::OpReply, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF), 1'b1, 2'd0, none, none);
    add_row(pkt(arpc_pkg::OpRequest, 32'hFFFF_FFFF, 48'h0123_4567_89AB), 1'b1, 2'd1,
            res(arpc_pkg::ActReply, 32'hFFFF_FFFF, 48'h0123_4567_89AB, 4'd1, 1'b1), none);
    for (int k = 0; k < 14; k++)
      add_row(pkt(arpc_pkg::OpReply, 32'h0A00_0002 + k, 48'h0200_0000_0000 + k), 1'b1, 2'd0,
              none, none);
    // Table is full now: the full beat comes before the reply.
    add_row(pkt(arpc_pkg::OpRequest, 32'hC0A8_0001, 48'h00AA_BBCC_DDEE), 1'b1, 2'd2,
            res(arpc_pkg::ActFull, 32'hC0A8_0001, 48'h00AA_BBCC_DDEE, 4'd0, 1'b0),
            res(arpc_pkg::ActReply, 32'hC0A8_0001, 48'h00AA_BBCC_DDEE, 4'd0, 1'b1));
    add_row(pkt(arpc_pkg::OpReply, 32'hC0A8_0002, 48'h8000_0000_0001), 1'b1, 2'd1,
            res(arpc_pkg::ActFull, 32'hC0A8_0002, 48'h8000_0000_0001, 4'd0, 1'b1), none);
    // With one-tick timeouts and a budget of two, all sixteen entries expire together:
    // unicast, then broadcast, then freed. Opcode fields on a tick are ignored.
    add_row(tick_item(arpc_pkg::OpRequest), 1'b0, 2'd0, none, none);
    add_row(tick_item(arpc_pkg::OpReply), 1'b0, 2'd0, none, none);
    add_row(tick_item(16'hFFFF), 1'b0, 2'd0, none, none);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_config(8'd1, 8'd1, 8'd2);
    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].item, !directed_rows[r].typed);
      if (directed_rows[r].typed) begin
        if (directed_rows[r].n_res > 0)
          pending_actions = {pending_actions, directed_rows[r].r0};
        if (directed_rows[r].n_res > 1)
          pending_actions = {pending_actions, directed_rows[r].r1};
      end
    end

    run_phase(arpc_pkg::EntryTimeoutRst, arpc_pkg::PendingTimeoutRst, arpc_pkg::MaxRetriesRst,
              0, 0, 60);
    run_phase(8'd1, 8'd1, 8'd1, 87, 0, 60);
    run_phase(8'd255, 8'd255, 8'd255, 0, 87, 60);
    // Zero loads wrap to 255 on the first decrement.
    run_phase(8'd0, 8'd2, 8'd0, 7, 7, 60);
    run_phase(8'd3, 8'd2, 8'd4, 0, 0, 60);

    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_actions.size() != 0 && waited < 200_000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (40) @(posedge clk_i);
    if (pending_actions.size() != 0)
      flag_error($sformatf("%0d expected beats never arrived", pending_actions.size()));

    if (error_count == 0) begin
      $display("[arp_cache_aging_retry] OK");
    end else begin
      $display("[arp_cache_aging_retry] ERROR");
    end
    $finish;
  end

endmodule
